FILE: rtl/core/tree_split_frequency_counter_core_macros.svh
// assertion macros shared by the core
`ifndef TREE_SPLIT_FREQUENCY_COUNTER_CORE_MACROS_SVH
`define TREE_SPLIT_FREQUENCY_COUNTER_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define TSFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen
`define TSFC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/core/tsfc_pkg.sv
package tsfc_pkg;

  localparam int unsigned MaxTips   = 64;
  localparam int unsigned MaxSplits = 1024;
  localparam int unsigned NodeDepth = 64;

  localparam int unsigned NodeAw  = $clog2(NodeDepth);
  localparam int unsigned SplitAw = $clog2(MaxSplits);
  localparam int unsigned EntryW  = SplitAw + 1;
  localparam int unsigned MaskW   = MaxTips;
  localparam int unsigned CntW    = 16;
  localparam int unsigned TblW    = MaskW + CntW;
  localparam int unsigned NodeW   = 7;

  localparam logic [CntW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    REQ_EDGE = 2'd0,
    REQ_END  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_EDGE_C  = 12'b0000_0000_0010,
    S_EDGE_P  = 12'b0000_0000_0100,
    S_LOAD_RD = 12'b0000_0000_1000,
    S_LOAD_WR = 12'b0000_0001_0000,
    S_MRD     = 12'b0000_0010_0000,
    S_MLAT    = 12'b0000_0100_0000,
    S_SCAN    = 12'b0000_1000_0000,
    S_APPEND  = 12'b0001_0000_0000,
    S_READ    = 12'b0010_0000_0000,
    S_FIN     = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [NodeAw-1:0] rd_addr;
    logic              wr_en;
    logic [NodeAw-1:0] wr_addr;
    logic [MaskW-1:0]  wr_data;
    logic              clear;
  } node_req_t;

endpackage

FILE: rtl/core/tree_split_frequency_counter_core.sv
// channel | handshake               | payload
// in      | in_valid_i / in_ready_o | req_type_i parent_node_i child_node_i entry_index_i
// out     | out_valid_o/out_ready_i | tip_set_o split_count_o entry_valid_o num_entries_o
//         |                         | overflow_o
// cfg     | cfg_we_i                | cfg_wdata_i (num_tips)
// one word at a time: an edge steps through child read, parent read and write back,
// a table read through its entry read, a no-op straight on to the result register
// end of tree loads node masks into an empty split table, else walks them against it,
// one table entry per cycle
// reset clears the state machine, counts and flags; node masks are tracked by valid bits, no sweep
// a waiting result does not block the next accept; a new result waits for the register
module tree_split_frequency_counter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [6:0]                     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [tsfc_pkg::NodeW-1:0]     parent_node_i,
  input  logic [tsfc_pkg::NodeW-1:0]     child_node_i,
  input  logic [tsfc_pkg::SplitAw-1:0]   entry_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tsfc_pkg::MaskW-1:0]     tip_set_o,
  output logic [tsfc_pkg::CntW-1:0]      split_count_o,
  output logic                           entry_valid_o,
  output logic [tsfc_pkg::EntryW-1:0]    num_entries_o,
  output logic                           overflow_o
);
  import tsfc_pkg::*;

  `include "tree_split_frequency_counter_core_macros.svh"

  state_e               state_q, state_d;
  logic [NodeW-1:0]     num_tips_q;
  logic [NodeW-1:0]     nt;
  logic [EntryW-1:0]    entry_total_q, entry_total_d;
  logic [CntW-1:0]      tree_total_q, tree_total_d;
  logic [NodeW-1:0]     hp_q, hp_d;
  logic                 ovf_q, ovf_d;
  logic [NodeAw-1:0]    pj_q, pj_d;
  logic [NodeW-1:0]     p_q, p_d;
  logic [MaskW-1:0]     add_q, add_d;
  logic                 use_child_q, use_child_d;
  logic [SplitAw-1:0]   idx_q, idx_d;
  logic [NodeW-1:0]     i_q, i_d;
  logic [NodeW-1:0]     nnode_q, nnode_d;
  logic [EntryW-1:0]    e_q, e_d;
  logic [MaskW-1:0]     mask_q, mask_d;
  logic [MaskW-1:0]     rtip_q, rtip_d;
  logic [CntW-1:0]      rcnt_q, rcnt_d;
  logic                 rvld_q, rvld_d;
  logic                 out_valid_q, out_valid_d;
  logic [MaskW-1:0]     out_tip_q, out_tip_d;
  logic [CntW-1:0]      out_cnt_q, out_cnt_d;
  logic                 out_vld_q, out_vld_d;
  logic [EntryW-1:0]    out_ne_q, out_ne_d;
  logic                 out_ovf_q, out_ovf_d;

  node_req_t            node_req;
  logic [MaskW-1:0]     node_rdata;
  logic                 tbl_we, tbl_re;
  logic [SplitAw-1:0]   tbl_waddr, tbl_raddr;
  logic [TblW-1:0]      tbl_wdata, tbl_rdata;

  logic                 accept;
  logic [NodeW:0]       p_off, c_off, hp_off;
  logic                 p_ok, c_int, c_int_ok;
  logic [NodeW-1:0]     nnode_acc, i_inc;
  logic [EntryW-1:0]    e_inc;
  logic [CntW-1:0]      hit_cnt;

  tsfc_node_store u_node_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (node_req),
    .rd_data_o(node_rdata)
  );

  tsfc_ram #(
    .Width(TblW),
    .Depth(MaxSplits)
  ) u_split_table (
    .clk_i    (clk_i),
    .wr_en_i  (tbl_we),
    .wr_addr_i(tbl_waddr),
    .wr_data_i(tbl_wdata),
    .rd_en_i  (tbl_re),
    .rd_addr_i(tbl_raddr),
    .rd_data_o(tbl_rdata)
  );

  assign nt       = (num_tips_q > NodeW'(MaxTips)) ? NodeW'(MaxTips) : num_tips_q;
  assign accept   = in_valid_i && in_ready_o;
  assign p_off    = {1'b0, parent_node_i} - {1'b0, nt} - (NodeW+1)'(1);
  assign c_off    = {1'b0, child_node_i} - {1'b0, nt} - (NodeW+1)'(1);
  assign p_ok     = (parent_node_i > nt) && (p_off < (NodeW+1)'(NodeDepth));
  assign c_int    = child_node_i > nt;
  assign c_int_ok = c_int && (c_off < (NodeW+1)'(NodeDepth));
  assign hp_off   = {1'b0, hp_q} - {1'b0, nt};
  assign nnode_acc = (hp_q <= nt) ? '0 :
                     (hp_off > (NodeW+1)'(NodeDepth)) ? NodeW'(NodeDepth) : hp_off[NodeW-1:0];
  assign i_inc    = i_q + NodeW'(1);
  assign e_inc    = e_q + EntryW'(1);
  assign hit_cnt  = (tbl_rdata[CntW-1:0] == CountMax) ? CountMax
                                                      : tbl_rdata[CntW-1:0] + CntW'(1);

  always_comb begin
    state_d       = state_q;
    entry_total_d = entry_total_q;
    tree_total_d  = tree_total_q;
    hp_d          = hp_q;
    ovf_d         = ovf_q;
    pj_d          = pj_q;
    p_d           = p_q;
    add_d         = add_q;
    use_child_d   = use_child_q;
    idx_d         = idx_q;
    i_d           = i_q;
    nnode_d       = nnode_q;
    e_d           = e_q;
    mask_d        = mask_q;
    rtip_d        = rtip_q;
    rcnt_d        = rcnt_q;
    rvld_d        = rvld_q;
    out_tip_d     = out_tip_q;
    out_cnt_d     = out_cnt_q;
    out_vld_d     = out_vld_q;
    out_ne_d      = out_ne_q;
    out_ovf_d     = out_ovf_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    node_req      = '0;
    tbl_we        = 1'b0;
    tbl_re        = 1'b0;
    tbl_waddr     = '0;
    tbl_raddr     = '0;
    tbl_wdata     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rtip_d = '0;
          rcnt_d = '0;
          rvld_d = 1'b0;
          state_d = S_DONE;
          case (req_e'(req_type_i))
            REQ_EDGE: begin
              if (p_ok) begin
                pj_d        = p_off[NodeAw-1:0];
                p_d         = parent_node_i;
                use_child_d = c_int_ok;
                add_d       = (c_int || child_node_i == '0) ? '0
                            : MaskW'(1) << (child_node_i[NodeAw:0] - (NodeAw+1)'(1));
                node_req.rd_en   = c_int_ok;
                node_req.rd_addr = c_off[NodeAw-1:0];
                state_d          = S_EDGE_C;
              end
            end
            REQ_END: begin
              nnode_d = nnode_acc;
              if (entry_total_q == '0) begin
                i_d     = '0;
                state_d = (nnode_acc == '0) ? S_FIN : S_LOAD_RD;
              end else begin
                i_d     = NodeW'(1);
                state_d = (nnode_acc <= NodeW'(1)) ? S_FIN : S_MRD;
              end
            end
            REQ_READ: begin
              if ({1'b0, entry_index_i} < entry_total_q) begin
                idx_d     = entry_index_i;
                tbl_re    = 1'b1;
                tbl_raddr = entry_index_i;
                state_d   = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE_C: begin
        if (use_child_q) begin
          add_d = node_rdata;
        end
        node_req.rd_en   = 1'b1;
        node_req.rd_addr = pj_q;
        state_d          = S_EDGE_P;
      end
      S_EDGE_P: begin
        node_req.wr_en   = 1'b1;
        node_req.wr_addr = pj_q;
        node_req.wr_data = node_rdata | add_q;
        if (p_q > hp_q) begin
          hp_d = p_q;
        end
        state_d = S_DONE;
      end
      S_LOAD_RD: begin
        node_req.rd_en   = 1'b1;
        node_req.rd_addr = i_q[NodeAw-1:0];
        state_d          = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = SplitAw'(i_q[NodeAw-1:0]);
        tbl_wdata = {node_rdata, CntW'(1)};
        i_d       = i_inc;
        if (i_inc == nnode_q) begin
          entry_total_d = EntryW'(nnode_q);
          state_d       = S_FIN;
        end else begin
          state_d = S_LOAD_RD;
        end
      end
      S_MRD: begin
        node_req.rd_en   = 1'b1;
        node_req.rd_addr = i_q[NodeAw-1:0];
        state_d          = S_MLAT;
      end
      S_MLAT: begin
        mask_d = node_rdata;
        e_d    = EntryW'(1);
        if (entry_total_q > EntryW'(1)) begin
          tbl_re    = 1'b1;
          tbl_raddr = SplitAw'(1);
          state_d   = S_SCAN;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_SCAN: begin
        if (tbl_rdata[TblW-1:CntW] == mask_q) begin
          tbl_we    = 1'b1;
          tbl_waddr = e_q[SplitAw-1:0];
          tbl_wdata = {mask_q, hit_cnt};
          i_d       = i_inc;
          state_d   = (i_inc >= nnode_q) ? S_FIN : S_MRD;
        end else if (e_inc < entry_total_q) begin
          e_d       = e_inc;
          tbl_re    = 1'b1;
          tbl_raddr = e_inc[SplitAw-1:0];
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        if (entry_total_q < EntryW'(MaxSplits)) begin
          tbl_we        = 1'b1;
          tbl_waddr     = entry_total_q[SplitAw-1:0];
          tbl_wdata     = {mask_q, CntW'(1)};
          entry_total_d = entry_total_q + EntryW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        i_d     = i_inc;
        state_d = (i_inc >= nnode_q) ? S_FIN : S_MRD;
      end
      S_READ: begin
        rtip_d  = tbl_rdata[TblW-1:CntW];
        rcnt_d  = (idx_q == '0) ? tree_total_q : tbl_rdata[CntW-1:0];
        rvld_d  = 1'b1;
        state_d = S_DONE;
      end
      S_FIN: begin
        if (tree_total_q != CountMax) begin
          tree_total_d = tree_total_q + CntW'(1);
        end
        node_req.clear = 1'b1;
        hp_d           = '0;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_tip_d   = rtip_q;
          out_cnt_d   = rcnt_q;
          out_vld_d   = rvld_q;
          out_ne_d    = entry_total_q;
          out_ovf_d   = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      num_tips_q    <= NodeW'(MaxTips);
      entry_total_q <= '0;
      tree_total_q  <= '0;
      hp_q          <= '0;
      ovf_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_total_q <= entry_total_d;
      tree_total_q  <= tree_total_d;
      hp_q          <= hp_d;
      ovf_q         <= ovf_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        num_tips_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pj_q        <= pj_d;
    p_q         <= p_d;
    add_q       <= add_d;
    use_child_q <= use_child_d;
    idx_q       <= idx_d;
    i_q         <= i_d;
    nnode_q     <= nnode_d;
    e_q         <= e_d;
    mask_q      <= mask_d;
    rtip_q      <= rtip_d;
    rcnt_q      <= rcnt_d;
    rvld_q      <= rvld_d;
    out_tip_q   <= out_tip_d;
    out_cnt_q   <= out_cnt_d;
    out_vld_q   <= out_vld_d;
    out_ne_q    <= out_ne_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign tip_set_o     = out_tip_q;
  assign split_count_o = out_cnt_q;
  assign entry_valid_o = out_vld_q;
  assign num_entries_o = out_ne_q;
  assign overflow_o    = out_ovf_q;

  `TSFC_NEVER(a_entries_bound, entry_total_q > EntryW'(MaxSplits), "table count past capacity")
  `TSFC_ASSERT(a_ovf_on_full, $rose(ovf_q) |-> entry_total_q == EntryW'(MaxSplits), "early overflow")
  `TSFC_ASSERT(a_entries_grow, entry_total_q >= $past(entry_total_q), "table count shrank")
  `TSFC_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "stray result")

endmodule

FILE: rtl/core/tsfc_ram.sv
module tsfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: rtl/core/tsfc_node_store.sv
module tsfc_node_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsfc_pkg::node_req_t          req_i,
  output logic [tsfc_pkg::MaskW-1:0]   rd_data_o
);
  import tsfc_pkg::*;

  logic [NodeDepth-1:0] vld_q;
  logic                 rd_vld_q;
  logic [MaskW-1:0]     ram_rdata;

  tsfc_ram #(
    .Width(MaskW),
    .Depth(NodeDepth)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (req_i.wr_en),
    .wr_addr_i(req_i.wr_addr),
    .wr_data_i(req_i.wr_data),
    .rd_en_i  (req_i.rd_en),
    .rd_addr_i(req_i.rd_addr),
    .rd_data_o(ram_rdata)
  );

  // entries never written since the last tree read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? ram_rdata : '0;

endmodule
